/* src/smalu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package smalu_pkg;
  localparam int DataBits = 8;
  localparam int MagBits  = DataBits - 1;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // data handed from one iteration cell to the next
  typedef struct packed {
    logic                 is_div;
    logic [MagBits-1:0]   divisor;   // multiplicand or divisor
    logic [MagBits-1:0]   acc;       // partial remainder or high product half
    logic [MagBits-1:0]   sh;        // dividend/quotient or multiplier/low product
  } step_t;
endpackage
`default_nettype wire

/* src/smalu_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// One step of shift-add multiply or restoring divide.
module smalu_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  load,
  input  wire                  en,
  input  smalu_pkg::step_t     din,
  output smalu_pkg::step_t     dout
);
  import smalu_pkg::*;

  step_t              nxt;
  logic [MagBits:0]   sum;
  logic [MagBits:0]   trial;

  always_comb begin
    nxt = din;
    sum = '0;
    trial = '0;
    if (din.is_div) begin
      trial = {din.acc, din.sh[MagBits-1]};
      if (trial >= {1'b0, din.divisor}) begin
        trial = trial - {1'b0, din.divisor};
        nxt.sh = {din.sh[MagBits-2:0], 1'b1};
      end else begin
        nxt.sh = {din.sh[MagBits-2:0], 1'b0};
      end
      nxt.acc = trial[MagBits-1:0];
    end else begin
      sum = {1'b0, din.acc} + (din.sh[0] ? {1'b0, din.divisor} : '0);
      nxt.acc = sum[MagBits:1];
      nxt.sh = {sum[0], din.sh[MagBits-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (load || en) begin
      dout <= nxt;
    end
  end
endmodule
`default_nettype wire

/* src/sign_magnitude_alu_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sign-magnitude ALU on 8-bit codes (bit 7 sign): add, subtract, multiply, divide.
// One transaction in, one out. Add and subtract have the result registered in the cycle
// after acceptance; multiply and divide pass through a row of seven iteration
// cells, one per magnitude bit, stepping one cell per cycle, and the result is
// registered on the cycle after the last cell. One operation is in flight at a time:
// the result waits until taken, and the next input is accepted on the cycle after that.
module sign_magnitude_alu_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,  // mode[1:0], operand_a[9:2], operand_b[17:10], zero pad
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata   // result[15:0], remainder[22:16], overflow[23],
                                // div_by_zero[24], zero pad
);
  import smalu_pkg::*;

  state_t state, state_next;
  mode_t  mode;
  logic [DataBits-1:0] op_a, op_b;
  logic [2:0] cnt;
  step_t chain [0:MagBits];

  logic [15:0] res;
  logic [6:0]  rem;
  logic        ovf, dz;

  wire accept = s_tvalid && s_tready;
  wire [1:0] in_mode = s_tdata[1:0];
  wire [7:0] in_a = s_tdata[9:2];
  wire [7:0] in_b = s_tdata[17:10];

  always_ff @(posedge clk) begin
    if (accept) begin
      mode <= mode_t'(in_mode);
      op_a <= in_a;
      op_b <= in_b;
    end
  end

  // cell 0 input is the loaded operand set; later cells each run once
  always_comb begin
    chain[0].is_div  = (mode == MODE_DIV);
    chain[0].divisor = op_b[MagBits-1:0];
    chain[0].acc     = '0;
    chain[0].sh      = op_a[MagBits-1:0];
  end

  for (genvar i = 0; i < MagBits; i++) begin : g_cell
    smalu_cell u_cell (
      .clk (clk),
      .rst (rst),
      .load(1'b0),
      .en  (state == ST_RUN && cnt == 3'(i)),
      .din (chain[i]),
      .dout(chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) cnt <= '0;
      else if (state == ST_RUN) cnt <= cnt + 3'd1;
    end
  end

  // last cell is loaded while cnt is MagBits-1, so its output is ready when cnt reaches MagBits
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (mode == MODE_ADD || mode == MODE_SUB || cnt == 3'(MagBits))
          state_next = ST_DONE;
      end
      ST_DONE: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // add/subtract datapath and result select for all modes
  logic       sa, sb, sx;
  logic [6:0] ma, mb;
  logic [7:0] tot;
  logic [7:0] addr;
  always_comb begin
    sa  = op_a[7];
    sb  = op_b[7] ^ (mode == MODE_SUB);
    ma  = op_a[6:0];
    mb  = op_b[6:0];
    sx  = op_a[7] ^ op_b[7];
    tot = {1'b0, ma} + {1'b0, mb};
    ovf = 1'b0;
    if (sa == sb) begin
      addr = {sa, tot[6:0]};
      ovf  = tot[7];
    end else if (ma > mb) begin
      addr = {sa, ma - mb};
    end else begin
      addr = {sb, mb - ma};
    end
    if (mode == MODE_SUB && addr == 8'h80) addr = 8'h00;
    res = '0;
    rem = '0;
    dz  = 1'b0;
    case (mode)
      MODE_ADD, MODE_SUB: res = {8'h00, addr};
      MODE_MUL: begin
        ovf = 1'b0;
        res = {sx, 1'b0, chain[MagBits].acc, chain[MagBits].sh};
      end
      default: begin
        ovf = 1'b0;
        if (mb == '0) dz = 1'b1;
        else begin
          res = {8'h00, sx, chain[MagBits].sh};
          rem = chain[MagBits].acc;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_RUN && state_next == ST_DONE)
      m_tdata <= {7'd0, dz, ovf, rem, res};
  end

  assign m_tvalid = (state == ST_DONE);

  property p_out_holds;
    @(posedge clk) disable iff (rst) (m_tvalid && !m_tready) |=> m_tvalid;
  endproperty
  a_out_holds: assert property (p_out_holds) else $error("result dropped");

  property p_no_overlap;
    @(posedge clk) disable iff (rst) m_tvalid |-> !s_tready;
  endproperty
  a_no_overlap: assert property (p_no_overlap) else $error("input taken while busy");

  property p_cnt_range;
    @(posedge clk) disable iff (rst) (state == ST_RUN) |-> (cnt <= 3'(MagBits));
  endproperty
  a_cnt_range: assert property (p_cnt_range) else $error("cell count overrun");
endmodule
`default_nettype wire

/* bench/sign_magnitude_alu_unit_tb.sv */
`timescale 1ns / 1ps
module sign_magnitude_alu_unit_tb;
  import smalu_pkg::*;

  typedef struct packed {
    logic [15:0] result;
    logic [6:0]  remainder;
    logic        overflow;
    logic        div_by_zero;
  } alu_out_t;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  alu_out_t expected_q[$];
  int       n_errors = 0;
  int       n_results = 0;
  int       n_sent = 0;
  int       mode_count[4] = '{0, 0, 0, 0};
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_off = 0;
  int       quiet_cycles = 0;

  sign_magnitude_alu_unit i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // sign-magnitude add on 7-bit magnitudes
  function automatic logic [7:0] sm_sum(input logic [7:0] a, input logic [7:0] b,
                                        output logic carry);
    logic [7:0] total;
    carry = 1'b0;
    if (a[7] == b[7]) begin
      total = {1'b0, a[6:0]} + {1'b0, b[6:0]};
      carry = total[7];
      return {a[7], total[6:0]};
    end
    if (a[6:0] > b[6:0]) return {a[7], a[6:0] - b[6:0]};
    return {b[7], b[6:0] - a[6:0]};
  endfunction

  function automatic alu_out_t alu_predict(input mode_t mode, input logic [7:0] a,
                                           input logic [7:0] b);
    alu_out_t r;
    logic     sx;
    logic [7:0] s;
    r = '0;
    sx = a[7] ^ b[7];
    case (mode)
      MODE_ADD: r.result = {8'd0, sm_sum(a, b, r.overflow)};
      MODE_SUB: begin
        s = sm_sum(a, {~b[7], b[6:0]}, r.overflow);
        if (s == 8'h80) s = 8'h00;
        r.result = {8'd0, s};
      end
      MODE_MUL: r.result = {sx, 15'(a[6:0]) * 15'(b[6:0])};
      default: begin
        if (b[6:0] == 7'd0) begin
          r.div_by_zero = 1'b1;
        end else begin
          r.result = {8'd0, sx, 7'(a[6:0] / b[6:0])};
          r.remainder = a[6:0] % b[6:0];
        end
      end
    endcase
    return r;
  endfunction

  // tvalid stays up after acceptance until the next call or the drain drops it
  task automatic send_op(input mode_t mode, input logic [7:0] a, input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, b, a, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_q.push_back(alu_predict(mode, a, b));
    mode_count[mode]++;
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_code();
    case ($urandom_range(5))
      0: return {1'($urandom), 7'd0};
      1: return {1'($urandom), 7'h7f};
      2: return {1'($urandom), 7'($urandom_range(1, 3))};
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [7:0] codes[6] = '{8'h00, 8'h80, 8'h7f, 8'hff, 8'h01, 8'h81};
    send_op(MODE_ADD, 8'h7f, 8'h01);   // carry out
    send_op(MODE_ADD, 8'hff, 8'hff);
    send_op(MODE_ADD, 8'h05, 8'h85);   // equal magnitudes, b's sign
    send_op(MODE_ADD, 8'h85, 8'h05);
    send_op(MODE_ADD, 8'h85, 8'h03);
    send_op(MODE_SUB, 8'h85, 8'h85);   // equal magnitudes take b's flipped sign, here plus zero
    send_op(MODE_SUB, 8'h05, 8'h05);
    send_op(MODE_SUB, 8'h7f, 8'hff);
    send_op(MODE_SUB, 8'h80, 8'h00);
    send_op(MODE_MUL, 8'h7f, 8'h7f);
    send_op(MODE_MUL, 8'h80, 8'h05);   // zero product keeps xor sign
    send_op(MODE_MUL, 8'hff, 8'h7f);
    send_op(MODE_DIV, 8'h7f, 8'h00);   // divide by zero
    send_op(MODE_DIV, 8'h85, 8'h80);
    send_op(MODE_DIV, 8'h03, 8'h87);   // zero quotient keeps xor sign
    send_op(MODE_DIV, 8'hff, 8'h01);
    send_op(MODE_DIV, 8'h7f, 8'h0a);
    for (int i = 0; i < 6; i++) send_op(mode_t'(i % 4), codes[i], codes[5 - i]);
    wait_drained();
  endtask

  task automatic test_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_op(mode_t'($urandom_range(3)), rand_code(), rand_code());
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off for a long time while items keep coming
  task automatic test_backpressure();
    hold_off = 200;
    repeat (20) send_op(mode_t'($urandom_range(3)), rand_code(), rand_code());
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    alu_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[15:0], m_tdata[22:16], m_tdata[23], m_tdata[24]};
      n_results++;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected transaction %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: res %h/%h rem %h/%h ovf %b/%b dz %b/%b (exp/act)",
                     want.result, got.result, want.remainder, got.remainder,
                     want.overflow, got.overflow, want.div_by_zero, got.div_by_zero);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(110, 0, 0);
    test_random(100, 50, 0);
    test_random(100, 0, 50);
    test_random(100, 30, 30);
    test_backpressure();
    $display("%0d operations (add %0d, sub %0d, mul %0d, div %0d), %0d results checked",
             n_sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3], n_results);
    $display("%0d mismatches over idle, stall and long hold-off phases", n_errors);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* filelist.f */
src/smalu_pkg.sv
src/smalu_cell.sv
src/sign_magnitude_alu_unit.sv
bench/sign_magnitude_alu_unit_tb.sv
